@@ src/zzsd_pkg.sv @@
`timescale 1ns / 1ps

package zzsd_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned TimeW  = 64;
    localparam int unsigned WidthW = 31;
    localparam int unsigned CountW = 32;

    typedef enum logic [1:0] {
        PH_INIT  = 2'd0,
        PH_START = 2'd1,
        PH_UP    = 2'd2,
        PH_DOWN  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        TR_START = 2'd0,
        TR_UP    = 2'd1,
        TR_DOWN  = 2'd2
    } t_trend;

    typedef struct packed {
        t_phase                     phase;
        logic signed [ValueW-1:0]   extreme_value;
        logic [TimeW-1:0]           extreme_time;
        logic [CountW-1:0]          highs_seen;
        logic [CountW-1:0]          lows_seen;
        logic [CountW-1:0]          turns_seen;
    } t_state;

    // Field order runs from the highest bit down when packed into tdata
    typedef struct packed {
        logic [CountW-1:0]          turn_count;
        logic [CountW-1:0]          low_count;
        logic [CountW-1:0]          high_count;
        t_phase                     phase_now;
        logic                       new_low;
        logic                       new_high;
        t_trend                     peak_trend;
        logic [TimeW-1:0]           peak_time;
        logic signed [ValueW-1:0]   peak_value;
        logic                       peak_found;
    } t_result;

    localparam int unsigned ResultW = $bits(t_result);
    localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;
    localparam int unsigned InDataW = ValueW + TimeW;

endpackage

@@ src/zigzag_swing_detector_top.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s (in)    in   i_s_tvalid/o_s_tready i_s_tdata  96 bits
// m (out)   out  o_m_tvalid/i_m_tready o_m_tdata 200 bits
// cfg       in   i_cfg_we              i_cfg_wdata 31 bits (filter width)
//
// One sample per cycle while results are taken; an accepted sample passes
// an input register, then the swing update into the result register.
// Reset is synchronous, active low; it clears phase, extreme and counters
// and loads the filter width with 1.0.
// A stalled result holds its register; the input register drains into it
// as soon as the result is taken, so ready follows i_m_tready in the same cycle.

module zigzag_swing_detector_top
    import zzsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // [31:0] sample_value, [95:32] sample_time
    input  logic [InDataW-1:0]  i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // [0] peak_found, [32:1] peak_value, [96:33] peak_time, [98:97] peak_trend,
    // [99] new_high, [100] new_low, [102:101] phase_now, [134:103] high_count,
    // [166:135] low_count, [198:167] turn_count, [199] zero
    output logic [OutDataW-1:0] o_m_tdata,
    input  logic                i_cfg_we,
    input  logic [WidthW-1:0]   i_cfg_wdata
);

    localparam logic [WidthW-1:0] WidthReset = WidthW'(65536);

    logic [WidthW-1:0]         r_width;
    logic                      r_in_valid;
    logic signed [ValueW-1:0]  r_in_value;
    logic [TimeW-1:0]          r_in_time;
    t_state                    r_state;
    t_state                    n_state;
    t_result                   n_result;
    t_result                   r_result;
    logic                      r_out_valid;
    logic                      advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WidthReset;
        end else if (i_cfg_we) begin
            r_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_value <= i_s_tdata[ValueW-1:0];
            r_in_time  <= i_s_tdata[InDataW-1:ValueW];
        end
    end

    zzsd_step u_step (
        .i_state  (r_state),
        .i_width  (r_width),
        .i_value  (r_in_value),
        .i_time   (r_in_time),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_INIT, default: '0};
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OutDataW - ResultW){1'b0}}, r_result};

endmodule

@@ src/zzsd_step.sv @@
`timescale 1ns / 1ps

module zzsd_step
    import zzsd_pkg::*;
(
    input  t_state                    i_state,
    input  logic [WidthW-1:0]         i_width,
    input  logic signed [ValueW-1:0]  i_value,
    input  logic [TimeW-1:0]          i_time,
    output t_state                    o_state,
    output t_result                   o_result
);

    // 34-bit signed differences never overflow for 32-bit operands
    logic signed [ValueW+1:0] v_ext;
    logic signed [ValueW+1:0] x_ext;
    logic signed [ValueW+1:0] diff;
    logic signed [ValueW+1:0] mag;
    logic signed [ValueW+1:0] w_ext;
    logic                     above;
    logic                     below;

    assign v_ext = {{2{i_value[ValueW-1]}}, i_value};
    assign x_ext = {{2{i_state.extreme_value[ValueW-1]}}, i_state.extreme_value};
    assign w_ext = {3'b000, i_width};
    assign above = i_value > i_state.extreme_value;
    assign below = i_value < i_state.extreme_value;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        diff     = '0;
        mag      = '0;
        unique case (i_state.phase)
            PH_INIT: begin
                o_state.extreme_value = i_value;
                o_state.extreme_time  = i_time;
                o_state.phase         = PH_START;
                o_result.peak_found   = 1'b1;
                o_result.peak_value   = i_value;
                o_result.peak_time    = i_time;
                o_result.peak_trend   = TR_START;
            end
            PH_START: begin
                diff = v_ext - x_ext;
                mag  = diff[ValueW+1] ? -diff : diff;
                if (mag >= w_ext) begin
                    o_state.extreme_value = i_value;
                    o_state.extreme_time  = i_time;
                    // a flat move (width zero) counts as down
                    o_state.phase         = above ? PH_UP : PH_DOWN;
                end
            end
            PH_UP: begin
                if (above) begin
                    o_state.extreme_value = i_value;
                    o_state.extreme_time  = i_time;
                    o_state.highs_seen    = i_state.highs_seen + 1'b1;
                    o_result.new_high     = 1'b1;
                end else begin
                    diff = x_ext - v_ext;
                end
                if (diff >= w_ext) begin
                    o_state.turns_seen  = i_state.turns_seen + 1'b1;
                    o_result.peak_found = 1'b1;
                    o_result.peak_value = o_state.extreme_value;
                    o_result.peak_time  = o_state.extreme_time;
                    o_result.peak_trend = TR_UP;
                    if (diff != '0) begin
                        o_state.phase = PH_DOWN;
                    end
                end
            end
            PH_DOWN: begin
                if (below) begin
                    o_state.extreme_value = i_value;
                    o_state.extreme_time  = i_time;
                    o_state.lows_seen     = i_state.lows_seen + 1'b1;
                    o_result.new_low      = 1'b1;
                end else begin
                    diff = v_ext - x_ext;
                end
                if (diff >= w_ext) begin
                    o_state.turns_seen  = i_state.turns_seen + 1'b1;
                    o_result.peak_found = 1'b1;
                    o_result.peak_value = o_state.extreme_value;
                    o_result.peak_time  = o_state.extreme_time;
                    o_result.peak_trend = TR_DOWN;
                    if (diff != '0) begin
                        o_state.phase = PH_UP;
                    end
                end
            end
            default: ;
        endcase
        o_result.phase_now  = o_state.phase;
        o_result.high_count = o_state.highs_seen;
        o_result.low_count  = o_state.lows_seen;
        o_result.turn_count = o_state.turns_seen;
    end

endmodule

@@ tb/tb_zigzag_swing_detector_top.sv @@
`timescale 1ns / 1ps

module tb_zigzag_swing_detector_top;
    import zzsd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam logic signed [ValueW-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [ValueW-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic [WidthW-1:0] WIDTH_MAX = 31'h7FFF_FFFF;
    localparam logic [WidthW-1:0] WIDTH_ONE = 31'd65536;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [InDataW-1:0]  i_s_tdata = '0;
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [OutDataW-1:0] o_m_tdata;
    logic                i_cfg_we = 1'b0;
    logic [WidthW-1:0]   i_cfg_wdata = '0;

    // Tracker state mirrored from the block
    t_phase                   trk_phase = PH_INIT;
    logic signed [ValueW-1:0] ext_val = '0;
    logic [TimeW-1:0]         ext_time = '0;
    logic [CountW-1:0]        n_highs = '0;
    logic [CountW-1:0]        n_lows = '0;
    logic [CountW-1:0]        n_turns = '0;
    logic [WidthW-1:0]        swing_width = WIDTH_ONE;

    t_result     expected_swings[$];
    int unsigned n_errors = 0;
    int unsigned stalled_cycles = 0;
    bit          calm = 1'b0;

    zigzag_swing_detector_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_result swing_update(input logic signed [ValueW-1:0] v,
                                             input logic [TimeW-1:0] t);
        t_result r;
        longint  d;
        longint  w;
        r = '0;
        w = longint'({1'b0, swing_width});
        case (trk_phase)
            PH_INIT: begin
                ext_val = v;
                ext_time = t;
                trk_phase = PH_START;
                r.peak_found = 1'b1;
                r.peak_value = v;
                r.peak_time = t;
                r.peak_trend = TR_START;
            end
            PH_START: begin
                d = longint'(v) - longint'(ext_val);
                if (d < 0) d = -d;
                // equal values with zero width fall to down
                if (d >= w) begin
                    ext_time = t;
                    trk_phase = (v > ext_val) ? PH_UP : PH_DOWN;
                    ext_val = v;
                end
            end
            PH_UP: begin
                if (v > ext_val) begin
                    ext_val = v;
                    ext_time = t;
                    n_highs = n_highs + 1'b1;
                    r.new_high = 1'b1;
                end
                d = longint'(ext_val) - longint'(v);
                if (d >= w) begin
                    n_turns = n_turns + 1'b1;
                    r.peak_found = 1'b1;
                    r.peak_value = ext_val;
                    r.peak_time = ext_time;
                    r.peak_trend = TR_UP;
                    if (d > 0) trk_phase = PH_DOWN;
                end
            end
            default: begin
                if (v < ext_val) begin
                    ext_val = v;
                    ext_time = t;
                    n_lows = n_lows + 1'b1;
                    r.new_low = 1'b1;
                end
                d = longint'(v) - longint'(ext_val);
                if (d >= w) begin
                    n_turns = n_turns + 1'b1;
                    r.peak_found = 1'b1;
                    r.peak_value = ext_val;
                    r.peak_time = ext_time;
                    r.peak_trend = TR_DOWN;
                    if (d > 0) trk_phase = PH_UP;
                end
            end
        endcase
        r.phase_now = trk_phase;
        r.high_count = n_highs;
        r.low_count = n_lows;
        r.turn_count = n_turns;
        return r;
    endfunction

    function automatic logic signed [ValueW-1:0] clamp_q16(input longint x);
        if (x < longint'(VALUE_MIN)) return VALUE_MIN;
        if (x > longint'(VALUE_MAX)) return VALUE_MAX;
        return x[ValueW-1:0];
    endfunction

    task automatic send_sample(input logic signed [ValueW-1:0] v, input logic [TimeW-1:0] t);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 30) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {t, v};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_swings.push_back(swing_update(v, t));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_swings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [WidthW-1:0] w);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        swing_width = w;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, seen);
        end
    endtask

    // First sample, sub-width moves at the reset width, then a flat start move
    task automatic test_start_phase();
        send_sample(32'sd0, 64'd0);
        send_sample(32'sd65535, 64'd1);
        send_sample(-32'sd65535, 64'd2);
        set_width(31'd0);
        send_sample(32'sd0, 64'd3);
    endtask

    // Zero width: every sample in a trend reports, reversal only on a real retrace
    task automatic test_zero_width();
        send_sample(32'sd0, 64'd4);
        send_sample(-32'sd1, 64'd5);
        send_sample(32'sd5, 64'd6);
        send_sample(32'sd5, 64'd7);
        send_sample(32'sd4, 64'd8);
        send_sample(32'sd4, 64'd9);
    endtask

    task automatic test_full_range();
        set_width(WIDTH_MAX);
        send_sample(VALUE_MIN, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(VALUE_MAX, 64'h8000_0000_0000_0000);
        send_sample(VALUE_MAX, 64'h5555_5555_5555_5555);
        send_sample(-32'sd1, 64'hAAAA_AAAA_AAAA_AAAA);
        send_sample(VALUE_MIN, 64'h0000_0000_FFFF_FFFF);
        set_width(WIDTH_ONE);
        send_sample(VALUE_MIN + 32'sd65535, 64'hFFFF_FFFF_0000_0000);
        send_sample(VALUE_MIN + 32'sd65536, 64'h0123_4567_89AB_CDEF);
        send_sample(32'sh5555_5555, 64'hFEDC_BA98_7654_3210);
        send_sample(32'sh5554_5555, 64'h0);
        send_sample(32'sh5554_5554, 64'h1);
    endtask

    // Random walk in legs scaled to the width, with hits on the exact retrace
    // boundary and some full-range noise to break the sequences
    task automatic test_random_swings(input logic [WidthW-1:0] w, input int n_items,
                                      input bit quiet);
        longint      level;
        longint      span;
        logic [63:0] stamp;
        int          roll;
        bit          rising;
        set_width(w);
        calm = quiet;
        level = longint'(ext_val);
        rising = 1'($urandom_range(0, 1));
        stamp = {32'h0, $urandom()};
        span = longint'({1'b0, w}) / 2 + 4;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                level = longint'($signed($urandom()));
            end else if (roll < 20) begin
                level = (trk_phase == PH_UP) ? longint'(ext_val) - longint'({1'b0, w})
                                             : longint'(ext_val) + longint'({1'b0, w});
                level = level + longint'($urandom_range(0, 2)) - 1;
            end else begin
                if ($urandom_range(0, 99) < 25) rising = !rising;
                if (rising) level = level + longint'($urandom_range(0, 32'(span)));
                else level = level - longint'($urandom_range(0, 32'(span)));
            end
            level = longint'(clamp_q16(level));
            if ($urandom_range(0, 99) < 5) stamp = {$urandom(), $urandom()};
            else stamp = stamp + $urandom_range(1, 1000);
            send_sample(level[ValueW-1:0], stamp);
        end
        calm = 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen = t_result'(o_m_tdata[ResultW-1:0]);
            if (expected_swings.size() == 0) begin
                n_errors++;
                $display("%0t: result beat with none expected, actual %0h", $time, o_m_tdata);
            end else begin
                want = expected_swings.pop_front();
                check_field("peak_found", want.peak_found, seen.peak_found);
                check_field("peak_value", want.peak_value, seen.peak_value);
                check_field("peak_time", want.peak_time, seen.peak_time);
                check_field("peak_trend", want.peak_trend, seen.peak_trend);
                check_field("new_high", want.new_high, seen.new_high);
                check_field("new_low", want.new_low, seen.new_low);
                check_field("phase_now", want.phase_now, seen.phase_now);
                check_field("high_count", want.high_count, seen.high_count);
                check_field("low_count", want.low_count, seen.low_count);
                check_field("turn_count", want.turn_count, seen.turn_count);
                check_field("pad", 64'd0, o_m_tdata[OutDataW-1:ResultW]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stalled_cycles <= 0;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("zigzag_swing_detector_top test failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_start_phase();
        test_zero_width();
        test_full_range();
        test_random_swings(WIDTH_ONE, 150, 1'b0);
        test_random_swings(31'd0, 120, 1'b0);
        test_random_swings(WIDTH_MAX, 120, 1'b0);
        test_random_swings(31'($urandom_range(1, 32'h7FFF_FFFF)), 150, 1'b0);
        test_random_swings(31'($urandom_range(1, 32'h0010_0000)), 200, 1'b1);
        test_random_swings(31'd1, 150, 1'b0);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("zigzag_swing_detector_top test passed");
        end else begin
            $display("zigzag_swing_detector_top test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/zzsd_pkg.sv
src/zzsd_step.sv
src/zigzag_swing_detector_top.sv
tb/tb_zigzag_swing_detector_top.sv
